// ===== rtl/core/ordered_list_insert_delete_find_macros.svh =====
// Assertion macros shared by the ordered list RTL.
`ifndef ORDERED_LIST_INSERT_DELETE_FIND_MACROS_SVH
`define ORDERED_LIST_INSERT_DELETE_FIND_MACROS_SVH
`ifndef ASSERT_OFF
// Antecedent holds in this cycle implies consequent in the same cycle
`define OLIDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent holds in this cycle implies consequent in the next cycle
`define OLIDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define OLIDF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg)
`define OLIDF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== rtl/core/olidf_pkg.sv =====
// Types, codes and constants for the ordered list block.
package olidf_pkg;

    // List geometry
    localparam int DEPTH  = 64;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int POS_W  = 7;
    localparam int LEN_W  = 7;
    localparam int FIDX_W = 6;
    localparam int DATA_W = 32;
    // Compare width: holds count + 1 and any position
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Opcodes
    localparam logic [1:0] OP_FIND   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_DELETE = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_RANGE    = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [1:0]               opcode;
        logic [POS_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [FIDX_W-1:0] found_index;
        logic [LEN_W-1:0]  length;
    } rsp_t;

    // Per-cell control from the sequencer
    typedef struct packed {
        logic cmp_en;
        logic in_list;
        logic load_val;
        logic from_left;
        logic from_right;
    } cell_ctrl_t;

    // Mask of cell indexes whose bit b is set
    function automatic logic [DEPTH-1:0] idx_mask(input int b);
        logic [DEPTH-1:0] m;
        m = '0;
        for (int i = 0; i < DEPTH; i++) begin
            m[i] = ((i >> b) & 1) != 0;
        end
        return m;
    endfunction

endpackage

// ===== rtl/core/ordered_list_insert_delete_find.sv =====
// Ordered list top level: sequencer, row of list cells and match encoder.
// A command passes through the idle, execute (cell update and compare) and result
// (encode) states; no new command is taken until the result is loaded, and a stalled
// result holds the sequencer until it is taken.
// Reset clears the length, sequencer and result valid; cell contents are
// undefined until written.
`include "ordered_list_insert_delete_find_macros.svh"

module ordered_list_insert_delete_find (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  olidf_pkg::cmd_t   cmd,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output olidf_pkg::rsp_t   rsp
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    localparam logic [olidf_pkg::CMP_W-1:0] DEPTH_C = olidf_pkg::CMP_W'(olidf_pkg::DEPTH);
    localparam logic [olidf_pkg::CMP_W-1:0] ONE_C   = olidf_pkg::CMP_W'(1);

    state_t                        state_reg, state_next;
    olidf_pkg::cmd_t               cmd_reg, cmd_next;
    logic [olidf_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [1:0]                    status_reg, status_next;
    logic                          find_reg, find_next;
    olidf_pkg::rsp_t               rsp_reg, rsp_next;
    logic                          rsp_valid_reg, rsp_valid_next;

    logic                          accept;
    logic                          rsp_load;
    logic [olidf_pkg::CMP_W-1:0]   pos_c;
    logic [olidf_pkg::CMP_W-1:0]   cnt_c;
    logic [olidf_pkg::CMP_W-1:0]   slot_c;
    logic                          ins_ok;
    logic                          del_ok;
    logic                          exec;
    logic [olidf_pkg::DEPTH-1:0]   match_vec;
    logic signed [olidf_pkg::DATA_W-1:0] cell_data [olidf_pkg::DEPTH];
    logic                          enc_found;
    logic [olidf_pkg::IDX_W-1:0]   enc_index;

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign exec      = (state_reg == S_EXEC);
    assign rsp_load  = (state_reg == S_RESP) && (!rsp_valid_reg || !rsp_stall);

    // Command decode against the current length
    assign pos_c  = olidf_pkg::CMP_W'(cmd_reg.position);
    assign cnt_c  = olidf_pkg::CMP_W'(count_reg);
    assign slot_c = pos_c - ONE_C;
    assign ins_ok = (cmd_reg.opcode == olidf_pkg::OP_INSERT) && (cnt_c < DEPTH_C)
                    && (pos_c >= ONE_C) && (pos_c <= cnt_c + ONE_C);
    assign del_ok = (cmd_reg.opcode == olidf_pkg::OP_DELETE)
                    && (pos_c >= ONE_C) && (pos_c <= cnt_c);

    // Row of cells
    for (genvar i = 0; i < olidf_pkg::DEPTH; i++)
    begin : g_cell
        localparam logic [olidf_pkg::CMP_W-1:0] CELL_I = olidf_pkg::CMP_W'(i);
        olidf_pkg::cell_ctrl_t               ctrl;
        logic signed [olidf_pkg::DATA_W-1:0] left_d;
        logic signed [olidf_pkg::DATA_W-1:0] right_d;

        assign ctrl.cmp_en     = exec;
        assign ctrl.in_list    = (CELL_I < cnt_c);
        assign ctrl.load_val   = exec && ins_ok && (CELL_I == slot_c);
        assign ctrl.from_left  = exec && ins_ok && (CELL_I > slot_c);
        assign ctrl.from_right = exec && del_ok && (CELL_I >= slot_c);

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_inner_l
            assign left_d = cell_data[i-1];
        end

        if (i == olidf_pkg::DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_inner_r
            assign right_d = cell_data[i+1];
        end

        olidf_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .value      (cmd_reg.value),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .match      (match_vec[i])
        );
    end

    olidf_enc u_enc (
        .match_vec (match_vec),
        .found     (enc_found),
        .index     (enc_index)
    );

    // Sequencer, length and result register
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        status_next    = status_reg;
        find_next      = find_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                find_next   = 1'b0;
                status_next = olidf_pkg::ST_OK;
                case (cmd_reg.opcode)
                    olidf_pkg::OP_FIND:
                    begin
                        find_next = 1'b1;
                    end
                    olidf_pkg::OP_INSERT:
                    begin
                        if (cnt_c >= DEPTH_C)
                        begin
                            status_next = olidf_pkg::ST_FULL;
                        end
                        else if (!ins_ok)
                        begin
                            status_next = olidf_pkg::ST_RANGE;
                        end
                        else
                        begin
                            count_next = count_reg + olidf_pkg::CNT_W'(1);
                        end
                    end
                    olidf_pkg::OP_DELETE:
                    begin
                        if (!del_ok)
                        begin
                            status_next = olidf_pkg::ST_RANGE;
                        end
                        else
                        begin
                            count_next = count_reg - olidf_pkg::CNT_W'(1);
                        end
                    end
                    default:
                    begin
                        status_next = olidf_pkg::ST_OK;
                    end
                endcase
                state_next = S_RESP;
            end
            S_RESP:
            begin
                if (rsp_load)
                begin
                    rsp_next.length = olidf_pkg::LEN_W'(count_reg);
                    if (find_reg)
                    begin
                        rsp_next.status      = enc_found ? olidf_pkg::ST_OK
                                                         : olidf_pkg::ST_NOTFOUND;
                        rsp_next.found_index = enc_found
                                               ? olidf_pkg::FIDX_W'(enc_index) : '0;
                    end
                    else
                    begin
                        rsp_next.status      = status_reg;
                        rsp_next.found_index = '0;
                    end
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        find_reg   <= find_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Checks
    `OLIDF_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, olidf_pkg::CMP_W'(count_reg) <= DEPTH_C, "list length above depth")
    `OLIDF_ASSERT_NEXT(a_accept_exec, clk, rst_n, accept, state_reg == S_EXEC, "accepted command did not enter execute")
    `OLIDF_ASSERT_NEXT(a_count_hold, clk, rst_n, state_reg != S_EXEC, $stable(count_reg), "length changed outside execute")
    `OLIDF_ASSERT_NEXT(a_rsp_load, clk, rst_n, rsp_load, rsp_valid_reg && (state_reg == S_IDLE) && (rsp_reg.length == olidf_pkg::LEN_W'(count_reg)), "result not loaded with current length")

endmodule

// ===== rtl/core/olidf_cell.sv =====
// One list cell: holds an entry, shifts with its neighbors, compares in execute.
module olidf_cell (
    input  logic                                 clk,
    input  olidf_pkg::cell_ctrl_t                ctrl,
    input  logic signed [olidf_pkg::DATA_W-1:0]  value,
    input  logic signed [olidf_pkg::DATA_W-1:0]  left_data,
    input  logic signed [olidf_pkg::DATA_W-1:0]  right_data,
    output logic signed [olidf_pkg::DATA_W-1:0]  data,
    output logic                                 match
);

    logic signed [olidf_pkg::DATA_W-1:0] data_reg;
    logic signed [olidf_pkg::DATA_W-1:0] data_next;
    logic                                match_reg;
    logic                                match_next;

    // Entry update: load new value, shift up from left, shift down from right
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load_val)
        begin
            data_next = value;
        end
        else if (ctrl.from_left)
        begin
            data_next = left_data;
        end
        else if (ctrl.from_right)
        begin
            data_next = right_data;
        end
    end

    // Compare against the search value, only inside the list
    always_comb
    begin
        match_next = match_reg;
        if (ctrl.cmp_en)
        begin
            match_next = ctrl.in_list && (data_reg == value);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// ===== rtl/core/olidf_enc.sv =====
// Lowest-set-bit encoder over the cell match flags.
module olidf_enc (
    input  logic [olidf_pkg::DEPTH-1:0] match_vec,
    output logic                        found,
    output logic [olidf_pkg::IDX_W-1:0] index
);

    logic [olidf_pkg::DEPTH-1:0] lowest;

    // Isolate the lowest match
    assign lowest = match_vec & (~match_vec + olidf_pkg::DEPTH'(1));
    assign found  = |match_vec;

    // One-hot to binary
    always_comb
    begin
        index = '0;
        for (int b = 0; b < olidf_pkg::IDX_W; b++)
        begin
            index[b] = |(lowest & olidf_pkg::idx_mask(b));
        end
    end

endmodule
